// ===== src/trp_pkg.sv =====
`default_nettype none

package trp_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_HEIGHT_OFFSET = 2'd0;
    localparam logic [1:0] REG_TARGET_RATE   = 2'd1;
    localparam logic [1:0] REG_MAX_DISTANCE  = 2'd2;

    // Register reset values
    localparam logic [15:0] TARGET_RESET  = 16'h0A00;
    localparam logic [15:0] MAXDIST_RESET = 16'd4000;

    // Gain correction: distance = (raw * 2011 + 1024) / 2048
    localparam logic [10:0] GAIN_NUM   = 11'd2011;
    localparam int          GAIN_SHIFT = 11;
    localparam logic [26:0] GAIN_ROUND = 27'd1024;

    localparam logic [15:0] DSS_UNKNOWN = 16'h8000;
    localparam logic [15:0] SAT16       = 16'hFFFF;

    // Dense status codes
    localparam logic [3:0] ST_VALID    = 4'd0;
    localparam logic [3:0] ST_SIGMA    = 4'd1;
    localparam logic [3:0] ST_SIGNAL   = 4'd2;
    localparam logic [3:0] ST_MINRANGE = 4'd3;
    localparam logic [3:0] ST_BOUNDS   = 4'd4;
    localparam logic [3:0] ST_HARDWARE = 4'd5;
    localparam logic [3:0] ST_NOWRAP   = 4'd6;
    localparam logic [3:0] ST_WRAP     = 4'd7;
    localparam logic [3:0] ST_XTALK    = 4'd8;
    localparam logic [3:0] ST_SYNC     = 4'd9;
    localparam logic [3:0] ST_CLIPPED  = 4'd10;
    localparam logic [3:0] ST_NONE     = 4'd11;

    typedef struct packed {
        logic [4:0]  rng_status;
        logic [7:0]  stream_cnt;
        logic [15:0] spad_count;
        logic [15:0] ambient_rate;
        logic [15:0] range_raw;
        logic [15:0] peak_signal_rate;
        logic [31:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] rel_height;
        logic [3:0]  status_code;
        logic        reading_ok;
        logic [15:0] dss_spads;
        logic [31:0] delta_us;
        logic [31:0] sample_number;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic start_div1;
        logic start_div2;
        logic take_per_spad;
        logic take_need;
        logic set_unknown;
        logic load_out;
    } trp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic spads_zero;
        logic per_spad_zero;
        logic div_done;
    } trp_stat_t;

    // Map the sensor's raw range status onto the dense code set
    function automatic logic [3:0] map_status(input logic [4:0] raw, input logic [7:0] stream);
        logic [3:0] code;
        begin
            unique case (raw)
                5'd1, 5'd2, 5'd3, 5'd17: code = ST_HARDWARE;
                5'd13:                   code = ST_MINRANGE;
                5'd18:                   code = ST_SYNC;
                5'd5:                    code = ST_BOUNDS;
                5'd4:                    code = ST_SIGNAL;
                5'd6:                    code = ST_SIGMA;
                5'd7:                    code = ST_WRAP;
                5'd12:                   code = ST_XTALK;
                5'd8:                    code = ST_CLIPPED;
                5'd9:                    code = (stream == 8'd0) ? ST_NOWRAP : ST_VALID;
                default:                 code = ST_NONE;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/trp_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, 32 quotient bits per division.
module trp_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  count_reg, count_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsor_reg, dsor_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // Load the operands on start, else shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial      = {rem_reg, quo_reg[31]};
        diff       = trial - {1'b0, dsor_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsor_next  = dsor_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = 5'd0;
            rem_next   = 32'd0;
            quo_next   = dividend;
            dsor_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = diff[32] ? trial[31:0] : diff[31:0];
            quo_next   = {quo_reg[30:0], ~diff[32]};
            count_next = count_reg + 5'd1;
            if (count_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 5'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsor_reg <= dsor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/trp_datapath.sv =====
`default_nettype none

module trp_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire trp_pkg::trp_cmd_t  cmd,
    output trp_pkg::trp_stat_t      stat,
    input  wire trp_pkg::in_item_t  in_data,
    input  wire logic [15:0]        height_offset,
    input  wire logic [15:0]        target_rate,
    input  wire logic [15:0]        max_distance,
    output trp_pkg::out_item_t      out_data
);

    trp_pkg::in_item_t  item_reg;
    trp_pkg::out_item_t out_reg, out_next;

    logic [31:0] last_time_reg, last_time_next;
    logic        have_prev_reg, have_prev_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] delta_reg, delta_next;
    logic [31:0] per_spad_reg;
    logic [15:0] dss_reg;

    logic [16:0] rate_sum;
    logic [15:0] rate_sat;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quotient;

    logic [26:0] gain_prod;
    logic [15:0] corr_dist;
    logic [17:0] height_full;
    logic [15:0] height;
    logic [3:0]  status;

    // Sample numbering and time delta, taken as the item is accepted
    always_comb
    begin
        last_time_next = last_time_reg;
        have_prev_next = have_prev_reg;
        count_next     = count_reg;
        delta_next     = delta_reg;
        if (cmd.load_item)
        begin
            delta_next     = have_prev_reg ? (in_data.timestamp - last_time_reg) : 32'd0;
            count_next     = count_reg + 32'd1;
            last_time_next = in_data.timestamp;
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= 32'd0;
            have_prev_reg <= 1'b0;
            count_reg     <= 32'd0;
        end
        else
        begin
            last_time_reg <= last_time_next;
            have_prev_reg <= have_prev_next;
            count_reg     <= count_next;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        delta_reg <= delta_next;
    end

    // Rate per SPAD, then SPADs needed, through one shared divider
    always_comb
    begin
        rate_sum     = {1'b0, item_reg.peak_signal_rate} + {1'b0, item_reg.ambient_rate};
        rate_sat     = rate_sum[16] ? trp_pkg::SAT16 : rate_sum[15:0];
        div_start    = cmd.start_div1 | cmd.start_div2;
        div_dividend = cmd.start_div2 ? {target_rate, 16'd0} : {rate_sat, 16'd0};
        div_divisor  = cmd.start_div2 ? per_spad_reg : {16'd0, item_reg.spad_count};
    end

    trp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Hold the division results
    always_ff @(posedge clk)
    begin
        if (cmd.take_per_spad)
        begin
            per_spad_reg <= div_quotient;
        end
        if (cmd.set_unknown)
        begin
            dss_reg <= trp_pkg::DSS_UNKNOWN;
        end
        else if (cmd.take_need)
        begin
            dss_reg <= (div_quotient[31:16] != 16'd0) ? trp_pkg::SAT16 : div_quotient[15:0];
        end
    end

    // Distance, height, status and validity
    always_comb
    begin
        gain_prod   = {11'd0, item_reg.range_raw} * {16'd0, trp_pkg::GAIN_NUM}
                      + trp_pkg::GAIN_ROUND;
        corr_dist   = gain_prod[trp_pkg::GAIN_SHIFT +: 16];
        height_full = {2'b00, corr_dist} - {{2{height_offset[15]}}, height_offset};
        priority if (height_full[17])
            height = 16'd0;
        else if (height_full[16])
            height = trp_pkg::SAT16;
        else
            height = height_full[15:0];
        status = trp_pkg::map_status(item_reg.rng_status, item_reg.stream_cnt);

        out_next.distance      = corr_dist;
        out_next.rel_height    = height;
        out_next.status_code   = status;
        out_next.reading_ok    = (status == trp_pkg::ST_VALID) && (corr_dist != 16'd0)
                                 && (corr_dist <= max_distance);
        out_next.dss_spads     = dss_reg;
        out_next.delta_us      = delta_reg;
        out_next.sample_number = count_reg;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign stat.spads_zero    = (item_reg.spad_count == 16'd0);
    assign stat.per_spad_zero = (per_spad_reg == 32'd0);
    assign stat.div_done      = div_done;
    assign out_data           = out_reg;

endmodule

`default_nettype wire

// ===== src/trp_ctrl.sv =====
`default_nettype none

module trp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire trp_pkg::trp_stat_t stat,
    output trp_pkg::trp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START1,
        S_WAIT1,
        S_START2,
        S_WAIT2,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // Sequence one item through both divisions, skipping to finish on a zero divisor
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_free   = !out_valid_reg || out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_START1;
                end
            end
            S_START1:
            begin
                if (stat.spads_zero)
                begin
                    cmd.set_unknown = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.start_div1 = 1'b1;
                    state_next     = S_WAIT1;
                end
            end
            S_WAIT1:
            begin
                if (stat.div_done)
                begin
                    cmd.take_per_spad = 1'b1;
                    state_next        = S_START2;
                end
            end
            S_START2:
            begin
                if (stat.per_spad_zero)
                begin
                    cmd.set_unknown = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.start_div2 = 1'b1;
                    state_next     = S_WAIT2;
                end
            end
            S_WAIT2:
            begin
                if (stat.div_done)
                begin
                    cmd.take_need = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Drop valid once taken, raise it on a new result
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/tof_range_result_processor.sv =====
// Flow: an item passes two divisions on the single bit-serial divider, or skips both when
// the SPAD count is zero; a zero rate per SPAD skips the second division.
// A new item is taken only once the last result is loaded into the output register; the
// next item is taken while that result waits there, but finishing stalls until it is taken.
// Reset: asynchronous, active low; clears the sample counter, the previous timestamp and
// the registers to offset 0, target rate 0x0A00 and maximum distance 4000.
`default_nettype none

module tof_range_result_processor (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire trp_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output trp_pkg::out_item_t     out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] offset_reg;
    logic [15:0] target_reg;
    logic [15:0] maxdist_reg;
    logic        cfg_write;

    trp_pkg::trp_cmd_t  cmd;
    trp_pkg::trp_stat_t stat;

    // Configuration register writes
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= 16'd0;
            target_reg  <= trp_pkg::TARGET_RESET;
            maxdist_reg <= trp_pkg::MAXDIST_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                trp_pkg::REG_HEIGHT_OFFSET: offset_reg  <= pwdata[15:0];
                trp_pkg::REG_TARGET_RATE:   target_reg  <= pwdata[15:0];
                trp_pkg::REG_MAX_DISTANCE:  maxdist_reg <= pwdata[15:0];
                default:                    ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            trp_pkg::REG_HEIGHT_OFFSET: prdata = {16'd0, offset_reg};
            trp_pkg::REG_TARGET_RATE:   prdata = {16'd0, target_reg};
            trp_pkg::REG_MAX_DISTANCE:  prdata = {16'd0, maxdist_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    trp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    trp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_data       (in_data),
        .height_offset (offset_reg),
        .target_rate   (target_reg),
        .max_distance  (maxdist_reg),
        .out_data      (out_data)
    );

endmodule

`default_nettype wire
